@@ design/oui_pkg.sv @@
// ----------------------------------------------------------------------------
// oui_pkg: shared types and constants
// OUI prefix table and the control struct passed along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package oui_pkg;

  localparam int MacWidth    = 48;
  localparam int PrefixWidth = 24;
  localparam int CatWidth    = 3;
  localparam int CountWidth  = 8;
  localparam int GroupBit    = 40;
  localparam int RomHeld     = 65;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // broadcast along the chain each cycle
  typedef struct packed {
    logic                last;
    logic [MacWidth-1:0] mac;
    logic                kind;
  } probe_t;

  typedef struct packed {
    logic [PrefixWidth-1:0] prefix;
    logic [CatWidth-1:0]    cat;
  } rom_entry_t;

  function automatic rom_entry_t rom_entry(input logic [9:0] idx);
    rom_entry_t e;
    e = '{prefix: 24'h000000, cat: 3'd7};
    case (idx)
      10'd0:  e = '{24'hB41E52, 3'd0};
      10'd1:  e = '{24'h70C94E, 3'd0};
      10'd2:  e = '{24'h3C9180, 3'd0};
      10'd3:  e = '{24'hD8F3BC, 3'd0};
      10'd4:  e = '{24'h803049, 3'd0};
      10'd5:  e = '{24'hB83532, 3'd0};
      10'd6:  e = '{24'h145AFC, 3'd0};
      10'd7:  e = '{24'h744CA1, 3'd0};
      10'd8:  e = '{24'h083A88, 3'd0};
      10'd9:  e = '{24'h9C2F9D, 3'd0};
      10'd10: e = '{24'hC03532, 3'd0};
      10'd11: e = '{24'h940853, 3'd0};
      10'd12: e = '{24'hE4AAEA, 3'd0};
      10'd13: e = '{24'hF46ADD, 3'd0};
      10'd14: e = '{24'hF8A2D6, 3'd0};
      10'd15: e = '{24'h24B2B9, 3'd0};
      10'd16: e = '{24'h00F48D, 3'd0};
      10'd17: e = '{24'hD03957, 3'd0};
      10'd18: e = '{24'hE8D0FC, 3'd0};
      10'd19: e = '{24'hE04F43, 3'd0};
      10'd20: e = '{24'hB81EA4, 3'd0};
      10'd21: e = '{24'h700894, 3'd0};
      10'd22: e = '{24'h588E81, 3'd0};
      10'd23: e = '{24'hEC1BBD, 3'd0};
      10'd24: e = '{24'h3C71BF, 3'd0};
      10'd25: e = '{24'h5800E3, 3'd0};
      10'd26: e = '{24'h9035EA, 3'd0};
      10'd27: e = '{24'h5C93A2, 3'd0};
      10'd28: e = '{24'h646E69, 3'd0};
      10'd29: e = '{24'h4827EA, 3'd0};
      10'd30: e = '{24'hA4CF12, 3'd0};
      10'd31: e = '{24'h0025DF, 3'd1};
      10'd32: e = '{24'h0C9AE6, 3'd2};
      10'd33: e = '{24'h8C5823, 3'd2};
      10'd34: e = '{24'h04A85A, 3'd2};
      10'd35: e = '{24'h58B858, 3'd2};
      10'd36: e = '{24'hE47A2C, 3'd2};
      10'd37: e = '{24'h60601F, 3'd2};
      10'd38: e = '{24'h481CB9, 3'd2};
      10'd39: e = '{24'h34D262, 3'd2};
      10'd40: e = '{24'h00121C, 3'd2};
      10'd41: e = '{24'h00267E, 3'd2};
      10'd42: e = '{24'h9003B7, 3'd2};
      10'd43: e = '{24'h903AE6, 3'd2};
      10'd44: e = '{24'hA0143D, 3'd2};
      10'd45: e = '{24'h381D14, 3'd2};
      10'd46: e = '{24'h187F88, 3'd3};
      10'd47: e = '{24'h242BD6, 3'd3};
      10'd48: e = '{24'h343EA4, 3'd3};
      10'd49: e = '{24'h50E467, 3'd3};
      10'd50: e = '{24'h54E019, 3'd3};
      10'd51: e = '{24'h5C475E, 3'd3};
      10'd52: e = '{24'h649A63, 3'd3};
      10'd53: e = '{24'h90486C, 3'd3};
      10'd54: e = '{24'h9C7613, 3'd3};
      10'd55: e = '{24'hAC9FC3, 3'd3};
      10'd56: e = '{24'hC4DBAD, 3'd3};
      10'd57: e = '{24'hCC3BFB, 3'd3};
      10'd58: e = '{24'h00B463, 3'd3};
      10'd59: e = '{24'h7C2A9E, 3'd4};
      10'd60: e = '{24'hCC660A, 3'd4};
      10'd61: e = '{24'hF40343, 3'd4};
      10'd62: e = '{24'h5CE91E, 3'd4};
      10'd63: e = '{24'h985949, 3'd4};
      10'd64: e = '{24'h98DA92, 3'd4};
      default: e = '{24'h000000, 3'd7};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ design/oui_classify_and_unique_mac_count_top.sv @@
// The prefix search walks one ROM entry per cycle, stops at the first hit, and
//   a group address skips the prefix search and goes straight to the done state.
//   One item is handled at a time; the next input is accepted in the cycle after
//   the result transfer.
// Reset (rst, synchronous) clears all valid bits and category counters.
// ----------------------------------------------------------------------------
// oui_classify_and_unique_mac_count_top: MAC classifier and unique counter
// Endpoint dedup, OUI prefix lookup, and per-category first-seen counts.
// ----------------------------------------------------------------------------
`default_nettype none
module oui_classify_and_unique_mac_count_top #(
  parameter int ENDPOINT_ENTRIES = 256,
  parameter int SEEN_ENTRIES     = 128,
  parameter int OUI_ROM_ENTRIES  = 65,
  parameter int GROUP_COUNT      = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [47:0] mac,
  input  wire logic        endpoint_kind,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        new_endpoint,
  output      logic        endpoint_full,
  output      logic        group_address,
  output      logic        oui_hit,
  output      logic [2:0]  category,
  output      logic        newly_counted,
  output      logic        observed_full,
  output      logic [7:0]  category_total
);

  localparam int Limit  = (OUI_ROM_ENTRIES < oui_pkg::RomHeld) ?
                          OUI_ROM_ENTRIES : oui_pkg::RomHeld;
  localparam int IdxW   = 10;
  localparam int GroupW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  oui_pkg::state_t state, state_next;
  oui_pkg::probe_t probe;
  logic [oui_pkg::MacWidth-1:0] probe_mac;
  logic            probe_kind;
  logic [IdxW-1:0] idx;
  logic [7:0]      counts [GROUP_COUNT];
  logic            ep_found, ep_full, sn_found, sn_full;
  logic            ep_write, sn_write;
  logic            ep_pending;
  oui_pkg::rom_entry_t ent;
  logic            match;
  logic [7:0]      cur_count;

  assign probe = '{last: (idx == IdxW'(Limit - 1)), mac: probe_mac, kind: probe_kind};

  oui_table #(.Entries(ENDPOINT_ENTRIES), .UseKind(1'b1)) u_endpoint (
    .clk(clk), .rst(rst), .probe(probe), .write_en(ep_write),
    .found(ep_found), .full(ep_full)
  );

  oui_table #(.Entries(SEEN_ENTRIES), .UseKind(1'b0)) u_seen (
    .clk(clk), .rst(rst), .probe(probe), .write_en(sn_write),
    .found(sn_found), .full(sn_full)
  );

  assign ent   = oui_pkg::rom_entry(idx);
  assign match = (state == oui_pkg::ST_SCAN) && !group_address &&
                 32'(ent.cat) < GROUP_COUNT && ent.prefix == probe.mac[47:24];
  assign cur_count = counts[GroupW'(ent.cat)];
  assign in_stall  = (state != oui_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    sn_write   = 1'b0;
    case (state)
      oui_pkg::ST_IDLE: if (in_valid) state_next = oui_pkg::ST_SCAN;
      oui_pkg::ST_SCAN: begin
        if (match) begin
          sn_write   = 1'b1;
          state_next = oui_pkg::ST_DONE;
        end else if (probe.last || group_address) begin
          state_next = oui_pkg::ST_DONE;
        end
      end
      oui_pkg::ST_DONE: if (!out_stall) state_next = oui_pkg::ST_IDLE;
      default: state_next = oui_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= oui_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // endpoint lookup happens in the first scan cycle
  assign ep_write = ep_pending;
  always_ff @(posedge clk) begin
    if (rst) begin
      ep_pending <= 1'b0;
    end else begin
      ep_pending <= (state == oui_pkg::ST_IDLE) && in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < GROUP_COUNT; g++) counts[g] <= '0;
    end else if (match && !sn_found && !sn_full && cur_count != 8'hFF) begin
      counts[GroupW'(ent.cat)] <= cur_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == oui_pkg::ST_IDLE && in_valid) begin
      probe_mac      <= mac;
      probe_kind     <= endpoint_kind;
      idx            <= '0;
      group_address  <= mac[oui_pkg::GroupBit];
      oui_hit        <= 1'b0;
      category       <= '0;
      newly_counted  <= 1'b0;
      observed_full  <= 1'b0;
      category_total <= '0;
    end else if (state == oui_pkg::ST_SCAN) begin
      idx <= idx + IdxW'(1);
      if (match) begin
        oui_hit        <= 1'b1;
        category       <= ent.cat;
        newly_counted  <= !sn_found && !sn_full;
        observed_full  <= !sn_found && sn_full;
        category_total <= (!sn_found && !sn_full && cur_count != 8'hFF) ?
                          cur_count + 8'd1 : cur_count;
      end
    end
    if (ep_pending) begin
      new_endpoint  <= !ep_found && !ep_full;
      endpoint_full <= !ep_found && ep_full;
    end
  end

  assign out_valid = (state == oui_pkg::ST_DONE);

endmodule
`default_nettype wire

@@ design/oui_cell.sv @@
// ----------------------------------------------------------------------------
// oui_cell: one table slot
// Holds one address (and kind), matches the broadcast probe, and takes part
// in a first-free token chain that claims the lowest free slot.
// ----------------------------------------------------------------------------
`default_nettype none
module oui_cell #(
  parameter bit UseKind = 1'b1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire oui_pkg::probe_t probe,
  input  wire logic            claim,     // write this slot with the probe
  input  wire logic            free_in,   // a lower slot is free
  output      logic            free_out,
  output      logic            hit,
  output      logic            is_free
);

  logic                         valid;
  logic [oui_pkg::MacWidth-1:0] addr;
  logic                         kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      addr <= probe.mac;
      kind <= probe.kind;
    end
  end

  assign hit      = valid && addr == probe.mac && (!UseKind || kind == probe.kind);
  assign is_free  = !valid && !free_in;
  assign free_out = free_in || !valid;

endmodule
`default_nettype wire

@@ design/oui_table.sv @@
// ----------------------------------------------------------------------------
// oui_table: row of slot cells
// Combinational lookup: match over all cells, lowest free slot by chain.
// ----------------------------------------------------------------------------
`default_nettype none
module oui_table #(
  parameter int  Entries = 256,
  parameter bit  UseKind = 1'b1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire oui_pkg::probe_t probe,
  input  wire logic            write_en,  // store probe if new and room
  output      logic            found,
  output      logic            full
);

  logic [Entries:0]   chain;
  logic [Entries-1:0] hits;
  logic [Entries-1:0] frees;

  assign chain[0] = 1'b0;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    oui_cell #(.UseKind(UseKind)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe    (probe),
      .claim    (write_en && !found && frees[i]),
      .free_in  (chain[i]),
      .free_out (chain[i+1]),
      .hit      (hits[i]),
      .is_free  (frees[i])
    );
  end

  assign found = |hits;
  assign full  = !chain[Entries];

endmodule
`default_nettype wire
